// ===== hw/rtl/jhs_pkg.sv =====
// types, constants and codes shared by the joint histogram block
`default_nettype none

package jhs_pkg;

    localparam int DEF_VALUE_BITS    = 8;
    localparam int DEF_COUNT_BITS    = 8;
    localparam int DEF_OVERFLOW_BITS = 32;

    localparam int VALUE_FIELD_BITS = 8;
    localparam int COUNT_FIELD_BITS = 8;
    localparam int TOTAL_FIELD_BITS = 32;

    typedef enum logic [1:0] {
        CMD_ACCUM = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOOKUP,
        ST_REPLY
    } state_t;

    typedef struct packed {
        logic [1:0]                  cmd;
        logic [VALUE_FIELD_BITS-1:0] first_value;
        logic [VALUE_FIELD_BITS-1:0] second_value;
    } pair_word_t;

    typedef struct packed {
        logic [COUNT_FIELD_BITS-1:0] bin_count;
        logic                        saturated;
        logic [TOTAL_FIELD_BITS-1:0] overflow_total;
    } result_word_t;

    typedef struct packed {
        logic clear;
        logic bump;
    } ovf_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/jhs_bin_ram.sv =====
// single-port-write, registered-read memory holding the histogram bins
`default_nettype none

module jhs_bin_ram
    import jhs_pkg::*;
#(
    parameter int ADDR_BITS = 2 * DEF_VALUE_BITS,
    parameter int DATA_BITS = DEF_COUNT_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [DATA_BITS-1:0] wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [DATA_BITS-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem_array [DEPTH];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/jhs_ovf_counter.sv =====
// saturating overflow counter with synchronous clear
`default_nettype none

module jhs_ovf_counter
    import jhs_pkg::*;
#(
    parameter int BITS = DEF_OVERFLOW_BITS
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ovf_ctrl_t       ctrl,
    output logic      [BITS-1:0] value,
    output logic      [BITS-1:0] value_next
);

    logic [BITS-1:0] count_reg;

    always_comb
    begin
        value_next = count_reg;
        if (ctrl.clear)
        begin
            value_next = '0;
        end
        else if (ctrl.bump && (count_reg != '1))
        begin
            value_next = count_reg + BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= value_next;
        end
    end

    assign value = count_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/joint_histogram_saturating.sv =====
// Joint histogram of pixel pairs with saturating bins. Each accepted word is
// one command. Accumulate, read and the unused command first issue the bin
// memory read, then modify, write back and load the result register once the
// output register is free; the registered read of the bin memory sets this.
// Clear zeroes the overflow counter and sweeps the bin memory one entry per
// cycle over all 2^(2*VALUE_BITS) entries (65536 at the default), then loads
// its result register once the output register is free. After reset the same
// sweep runs, and no word is accepted until it ends. A finished result waits
// in the output register while the next word is taken.
`default_nettype none

module joint_histogram_saturating
    import jhs_pkg::*;
#(
    parameter int VALUE_BITS    = DEF_VALUE_BITS,
    parameter int COUNT_BITS    = DEF_COUNT_BITS,
    parameter int OVERFLOW_BITS = DEF_OVERFLOW_BITS
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         pair_valid,
    output logic              pair_ready,
    input  wire pair_word_t   pair,
    output logic              result_valid,
    input  wire logic         result_ready,
    output result_word_t      result
);

    localparam int ADDR_BITS = 2 * VALUE_BITS;
    localparam int VALUE_EXT_BITS =
        (VALUE_BITS > VALUE_FIELD_BITS) ? VALUE_BITS : VALUE_FIELD_BITS;
    localparam int COUNT_EXT_BITS =
        (COUNT_BITS > COUNT_FIELD_BITS) ? COUNT_BITS : COUNT_FIELD_BITS;
    localparam int TOTAL_EXT_BITS =
        (OVERFLOW_BITS > TOTAL_FIELD_BITS) ? OVERFLOW_BITS : TOTAL_FIELD_BITS;

    state_t                   state_reg, state_next;
    logic [ADDR_BITS-1:0]     sweep_addr_reg, sweep_addr_next;
    logic                     reply_reg, reply_next;
    cmd_t                     cmd_reg, cmd_next;
    logic [ADDR_BITS-1:0]     addr_reg, addr_next;
    logic                     out_valid_reg, out_valid_next;
    result_word_t             out_word_reg, out_word_next;

    logic [VALUE_EXT_BITS-1:0] row_ext, col_ext;
    logic [ADDR_BITS-1:0]      pair_addr;
    logic                      out_free;

    logic                      ram_we, ram_re;
    logic [ADDR_BITS-1:0]      ram_waddr;
    logic [COUNT_BITS-1:0]     ram_wdata, ram_rdata;

    ovf_ctrl_t                 ovf_ctrl;
    logic [OVERFLOW_BITS-1:0]  ovf_value, ovf_value_next;

    logic [COUNT_BITS-1:0]     count_new;
    logic [COUNT_EXT_BITS-1:0] count_ext;
    logic [TOTAL_EXT_BITS-1:0] total_ext;
    logic                      sat_flag;

    jhs_bin_ram #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (COUNT_BITS)
    ) u_bin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pair_addr),
        .rdata (ram_rdata)
    );

    jhs_ovf_counter #(
        .BITS (OVERFLOW_BITS)
    ) u_ovf_counter (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ovf_ctrl),
        .value      (ovf_value),
        .value_next (ovf_value_next)
    );

    assign row_ext   = VALUE_EXT_BITS'(pair.first_value);
    assign col_ext   = VALUE_EXT_BITS'(pair.second_value);
    assign pair_addr = {row_ext[VALUE_BITS-1:0], col_ext[VALUE_BITS-1:0]};
    assign out_free  = !out_valid_reg || result_ready;
    assign total_ext = TOTAL_EXT_BITS'(ovf_value_next);

    always_comb
    begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        reply_next      = reply_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_word_next   = out_word_reg;
        pair_ready      = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = '0;
        ovf_ctrl        = '0;
        count_new       = '0;
        sat_flag        = 1'b0;
        count_ext       = '0;

        case (state_reg)
            ST_SWEEP:
            begin
                ram_we          = 1'b1;
                ram_waddr       = sweep_addr_reg;
                sweep_addr_next = sweep_addr_reg + ADDR_BITS'(1);
                if (sweep_addr_reg == '1)
                begin
                    state_next = reply_reg ? ST_REPLY : ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                pair_ready = 1'b1;
                if (pair_valid)
                begin
                    cmd_next  = cmd_t'(pair.cmd);
                    addr_next = pair_addr;
                    if (cmd_t'(pair.cmd) == CMD_CLEAR)
                    begin
                        ovf_ctrl.clear  = 1'b1;
                        sweep_addr_next = '0;
                        reply_next      = 1'b1;
                        state_next      = ST_SWEEP;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = ST_LOOKUP;
                    end
                end
            end

            ST_LOOKUP:
            begin
                case (cmd_reg)
                    CMD_ACCUM:
                    begin
                        if (ram_rdata != '1)
                        begin
                            count_new = ram_rdata + COUNT_BITS'(1);
                        end
                        else
                        begin
                            count_new = ram_rdata;
                            sat_flag  = 1'b1;
                        end
                    end
                    CMD_READ:
                    begin
                        count_new = ram_rdata;
                    end
                    default:
                    begin
                        count_new = '0;
                    end
                endcase
                count_ext = COUNT_EXT_BITS'(count_new);
                if (out_free)
                begin
                    ram_we        = (cmd_reg == CMD_ACCUM) && !sat_flag;
                    ram_wdata     = count_new;
                    ovf_ctrl.bump = sat_flag;
                    out_valid_next               = 1'b1;
                    out_word_next.bin_count      = count_ext[COUNT_FIELD_BITS-1:0];
                    out_word_next.saturated      = sat_flag;
                    out_word_next.overflow_total = total_ext[TOTAL_FIELD_BITS-1:0];
                    state_next                   = ST_IDLE;
                end
            end

            ST_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_word_next.bin_count      = '0;
                    out_word_next.saturated      = 1'b0;
                    out_word_next.overflow_total = total_ext[TOTAL_FIELD_BITS-1:0];
                    reply_next                   = 1'b0;
                    state_next                   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            reply_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            reply_reg      <= reply_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        addr_reg     <= addr_next;
        out_word_reg <= out_word_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

endmodule

`default_nettype wire

// ===== verif/joint_histogram_saturating_test.sv =====
// self-checking testbench for the saturating joint histogram: queued stimulus, bin model, checks
module joint_histogram_saturating_test;
    import jhs_pkg::*;

    localparam int PHASE_ITEMS   = 320;
    localparam int SETTLE_CYCLES = 20;
    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int MAX_PRINTS    = 40;

    typedef enum logic [1:0] {
        PACE_RECV_SLOW,
        PACE_SEND_SLOW,
        PACE_FULL
    } pace_t;

    typedef struct packed {
        logic       hold;
        pace_t      pace;
        pair_word_t word;
    } queued_pair_t;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         pair_valid   = 1'b0;
    logic         pair_ready;
    pair_word_t   pair         = '0;
    logic         result_valid;
    logic         result_ready = 1'b0;
    result_word_t result;

    queued_pair_t pair_backlog[$];
    result_word_t predicted_results[$];
    bit [7:0]     bin_model [0:65535];
    bit [31:0]    overflow_model;

    pace_t        pace    = PACE_RECV_SLOW;
    bit           drained = 1'b1;
    queued_pair_t next_pair;
    result_word_t expected_word;
    int unsigned  gap_pct;
    int unsigned  stall_pct;

    int unsigned  mismatches;
    int unsigned  accum_seen;
    int unsigned  read_seen;
    int unsigned  clear_seen;
    int unsigned  unused_seen;
    int unsigned  full_hits;

    joint_histogram_saturating dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_ready   (pair_ready),
        .pair         (pair),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic result_word_t histogram_step(pair_word_t w);
        result_word_t r;
        logic [15:0]  addr;
        r    = '0;
        addr = {w.first_value, w.second_value};
        case (cmd_t'(w.cmd))
            CMD_ACCUM:
            begin
                if (bin_model[addr] != 8'hFF)
                begin
                    bin_model[addr] = bin_model[addr] + 8'd1;
                end
                else
                begin
                    r.saturated = 1'b1;
                    if (overflow_model != 32'hFFFF_FFFF)
                        overflow_model = overflow_model + 32'd1;
                end
                r.bin_count = bin_model[addr];
            end
            CMD_READ:
                r.bin_count = bin_model[addr];
            CMD_CLEAR:
            begin
                for (int i = 0; i < 65536; i++)
                    bin_model[i] = 8'd0;
                overflow_model = 32'd0;
            end
            default: ;
        endcase
        r.overflow_total = overflow_model;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTS)
            $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic queue_pair(input cmd_t cmd, input logic [7:0] row, input logic [7:0] col,
                              input logic hold, input pace_t p);
        queued_pair_t q;
        q.hold              = hold;
        q.pace              = p;
        q.word.cmd          = cmd;
        q.word.first_value  = row;
        q.word.second_value = col;
        pair_backlog.push_back(q);
    endtask

    // mostly pixel pairs landing on two hot bins so that they fill up
    task automatic queue_random(input logic [15:0] hot_a, input logic [15:0] hot_b,
                                input bit allow_clear, input pace_t p, input logic hold);
        int unsigned pick;
        logic [15:0] addr;
        pick = $urandom_range(0, 99);
        addr = 16'($urandom_range(0, 65535));
        if (pick < 55)
            queue_pair(CMD_ACCUM, hot_a[15:8], hot_a[7:0], hold, p);
        else if (pick < 63)
            queue_pair(CMD_ACCUM, hot_b[15:8], hot_b[7:0], hold, p);
        else if (pick < 73)
            queue_pair(CMD_ACCUM, addr[15:8], addr[7:0], hold, p);
        else if (pick < 83)
        begin
            addr = $urandom_range(0, 1) ? hot_a : hot_b;
            queue_pair(CMD_READ, addr[15:8], addr[7:0], hold, p);
        end
        else if (pick < 90)
            queue_pair(CMD_READ, addr[15:8], addr[7:0], hold, p);
        else if (pick < 96)
            queue_pair(CMD_NONE, addr[15:8], addr[7:0], hold, p);
        else if (pick < 97 && allow_clear)
            queue_pair(CMD_CLEAR, addr[15:8], addr[7:0], hold, p);
        else
            queue_pair(CMD_ACCUM, hot_a[15:8], hot_a[7:0], hold, p);
    endtask

    // pair driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid <= 1'b0;
            pair       <= '0;
        end
        else if (!pair_valid || pair_ready)
        begin
            if (pair_backlog.size() == 0)
            begin
                pair_valid <= 1'b0;
            end
            else
            begin
                next_pair = pair_backlog[0];
                case (next_pair.pace)
                    PACE_RECV_SLOW: gap_pct = 31;
                    PACE_SEND_SLOW: gap_pct = 67;
                    default:        gap_pct = 0;
                endcase
                // a held word waits until every result is back
                if (next_pair.hold && (pair_valid || !drained))
                    pair_valid <= 1'b0;
                else if ($urandom_range(0, 99) < gap_pct)
                    pair_valid <= 1'b0;
                else
                begin
                    pair       <= next_pair.word;
                    pair_valid <= 1'b1;
                    pace       <= next_pair.pace;
                    void'(pair_backlog.pop_front());
                end
            end
        end
    end

    // result receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            case (pace)
                PACE_RECV_SLOW: stall_pct = 67;
                PACE_SEND_SLOW: stall_pct = 31;
                default:        stall_pct = 0;
            endcase
            result_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pair_valid && pair_ready)
            begin
                predicted_results.push_back(histogram_step(pair));
                case (cmd_t'(pair.cmd))
                    CMD_ACCUM: accum_seen++;
                    CMD_READ:  read_seen++;
                    CMD_CLEAR: clear_seen++;
                    default:   unused_seen++;
                endcase
            end
            if (result_valid && result_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    report_mismatch("result with nothing expected", result.overflow_total, 0);
                end
                else
                begin
                    expected_word = predicted_results.pop_front();
                    if (result.bin_count !== expected_word.bin_count)
                        report_mismatch("bin_count", 32'(result.bin_count),
                                        32'(expected_word.bin_count));
                    if (result.saturated !== expected_word.saturated)
                        report_mismatch("saturated", 32'(result.saturated),
                                        32'(expected_word.saturated));
                    if (result.overflow_total !== expected_word.overflow_total)
                        report_mismatch("overflow_total", result.overflow_total,
                                        expected_word.overflow_total);
                    if (expected_word.saturated)
                        full_hits++;
                end
            end
            drained <= (predicted_results.size() == 0);
        end
    end

    initial
    begin
        logic [15:0] hot_a;
        logic [15:0] hot_b;
        logic [15:0] addr;
        int          n;

        // directed corners
        queue_pair(CMD_READ,  8'h00, 8'h00, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_ACCUM, 8'h00, 8'h00, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_ACCUM, 8'h00, 8'h00, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_ACCUM, 8'hFF, 8'hFF, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_ACCUM, 8'hFF, 8'h00, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_ACCUM, 8'h00, 8'hFF, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_ACCUM, 8'hAA, 8'h55, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_ACCUM, 8'h55, 8'hAA, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_READ,  8'hFF, 8'hFF, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_READ,  8'h00, 8'hFF, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_READ,  8'h80, 8'h7F, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_READ,  8'h55, 8'hAA, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_NONE,  8'hFF, 8'hFF, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_NONE,  8'h00, 8'h00, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_READ,  8'h00, 8'h00, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_READ,  8'hFF, 8'hFF, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_CLEAR, 8'hFF, 8'hFF, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_READ,  8'h00, 8'h00, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_READ,  8'hFF, 8'hFF, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_ACCUM, 8'h00, 8'h00, 1'b0, PACE_RECV_SLOW);
        queue_pair(CMD_NONE,  8'h5A, 8'hA5, 1'b0, PACE_RECV_SLOW);

        // two phases without a clear so the hot bin saturates
        hot_a = 16'($urandom_range(0, 65535));
        hot_b = 16'($urandom_range(0, 65535));
        for (n = 0; n < 2 * PHASE_ITEMS; n++)
        begin
            if (n < PHASE_ITEMS)
                queue_random(hot_a, hot_b, 1'b0, PACE_RECV_SLOW, n == 0);
            else
                queue_random(hot_a, hot_b, 1'b0, PACE_SEND_SLOW, n == PHASE_ITEMS);
        end

        // last phase opens with a clear and allows rare clears
        hot_a = 16'($urandom_range(0, 65535));
        hot_b = 16'($urandom_range(0, 65535));
        addr  = 16'($urandom_range(0, 65535));
        queue_pair(CMD_CLEAR, addr[15:8], addr[7:0], 1'b1, PACE_FULL);
        for (n = 0; n < PHASE_ITEMS; n++)
            queue_random(hot_a, hot_b, 1'b1, PACE_FULL, 1'b0);

        wait (rst_n);
        while (pair_backlog.size() != 0 || pair_valid || predicted_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d accumulates (%0d on full bins), %0d reads, %0d clears",
                 accum_seen, full_hits, read_seen, clear_seen);
        $display("plus %0d unused commands; final overflow count %0d, %0d mismatches",
                 unused_seen, overflow_model, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout with %0d words still expected", predicted_results.size());
        $display("simulation failed");
        $finish;
    end

endmodule
